[src/lnps_pkg.sv]
// Shared types and constants for the last-note priority stack.
// Used by lnps_ctrl, lnps_datapath and last_note_priority_stack; no dependencies.
package lnps_pkg;

  // Most notes kept in the held list (2 to 128)
  localparam int DEPTH     = 128;
  localparam int NOTE_W    = 7;
  localparam int NUM_NOTES = 2 ** NOTE_W;
  localparam int COUNT_W   = $clog2(DEPTH + 1);

  // Event kinds
  localparam logic MODE_OFF = 1'b0;
  localparam logic MODE_ON  = 1'b1;

  // Voice commands
  localparam logic CMD_PLAY    = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // take the input beat, read links of its note
    logic unlink;    // take the note out of the list if held
    logic drop_rd;   // read the link after the oldest note
    logic drop;      // remove the oldest note
    logic append;    // add the note as newest
    logic load_out;  // load the result register
  } lnps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mode_on;   // captured event is a note-on
    logic held_hit;  // captured note was held at capture time
    logic full;      // list holds DEPTH notes
  } lnps_sts_t;

endpackage

[src/lnps_ctrl.sv]
// Sequencer for the last-note priority stack: steps each event through
// unlink, then for a note-on an optional drop of the oldest note and append, then result. Uses lnps_pkg.
module lnps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  lnps_pkg::lnps_sts_t sts,
  output lnps_pkg::lnps_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UNLINK  = 3'd1;
  localparam logic [2:0] S_DROP_RD = 3'd2;
  localparam logic [2:0] S_DROP    = 3'd3;
  localparam logic [2:0] S_APPEND  = 3'd4;
  localparam logic [2:0] S_FINISH  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_busy;

  assign in_stall = (state != S_IDLE);
  assign out_busy = out_valid && out_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_UNLINK;
        end
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        if (sts.mode_on) begin
          if (!sts.held_hit && sts.full) begin
            state_next = S_DROP_RD;
          end else begin
            state_next = S_APPEND;
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DROP_RD: begin
        cmd.drop_rd = 1'b1;
        state_next  = S_DROP;
      end
      S_DROP: begin
        cmd.drop   = 1'b1;
        state_next = S_APPEND;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // An accepted beat always starts with the unlink step
  a_accept_unlink: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_UNLINK))
    else $error("accepted beat did not move to unlink");

  // A fresh result only comes out of the finish step
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result raised outside finish");

  // The oldest note is only dropped for a note-on that is not yet held
  a_drop_cause: assert property (@(posedge clk) disable iff (rst)
    (state == S_DROP_RD) |-> ($past(state) == S_UNLINK && sts.mode_on))
    else $error("drop of oldest note without a new note-on");

endmodule

[src/lnps_datapath.sv]
// Datapath: held notes as a doubly linked list in two link memories indexed
// by note, with held bits, head, tail, count and result register. Uses lnps_pkg.
module lnps_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              mode,
  input  logic [lnps_pkg::NOTE_W-1:0]       note,
  input  lnps_pkg::lnps_cmd_t               cmd,
  output lnps_pkg::lnps_sts_t               sts,
  output logic                              command,
  output logic [lnps_pkg::NOTE_W-1:0]       play_note,
  output logic                              retrigger
);

  // Link memories: older and newer neighbour of each held note
  logic [lnps_pkg::NOTE_W-1:0] prev_mem [lnps_pkg::NUM_NOTES];
  logic [lnps_pkg::NOTE_W-1:0] next_mem [lnps_pkg::NUM_NOTES];

  logic [lnps_pkg::NUM_NOTES-1:0] held;
  logic [lnps_pkg::COUNT_W-1:0]   held_count;
  logic [lnps_pkg::NOTE_W-1:0]    head;
  logic [lnps_pkg::NOTE_W-1:0]    tail;
  logic [lnps_pkg::NOTE_W-1:0]    note_r;
  logic                           mode_r;
  logic                           held_hit;
  logic [lnps_pkg::NOTE_W-1:0]    prev_rd;
  logic [lnps_pkg::NOTE_W-1:0]    next_rd;

  logic                           next_we;
  logic [lnps_pkg::NOTE_W-1:0]    next_waddr;
  logic [lnps_pkg::NOTE_W-1:0]    next_wdata;
  logic [lnps_pkg::NOTE_W-1:0]    next_raddr;
  logic                           prev_we;
  logic [lnps_pkg::NOTE_W-1:0]    prev_waddr;
  logic [lnps_pkg::NOTE_W-1:0]    prev_wdata;
  logic                           unlink_go;

  assign unlink_go = cmd.unlink && held_hit;

  assign sts.mode_on  = (mode_r == lnps_pkg::MODE_ON);
  assign sts.held_hit = held_hit;
  assign sts.full     = (held_count == lnps_pkg::COUNT_W'(lnps_pkg::DEPTH));

  // Link writes: bridge the gap on unlink, chain the new tail on append
  always_comb begin
    next_we    = (unlink_go && (note_r != head))
              || (cmd.append && (held_count != '0));
    next_waddr = cmd.unlink ? prev_rd : tail;
    next_wdata = cmd.unlink ? next_rd : note_r;
    prev_we    = (unlink_go && (note_r != tail)) || cmd.append;
    prev_waddr = cmd.unlink ? next_rd : note_r;
    prev_wdata = cmd.unlink ? prev_rd : tail;
    next_raddr = cmd.drop_rd ? head : note;
  end

  // Link memories
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (cmd.capture || cmd.drop_rd) begin
      next_rd <= next_mem[next_raddr];
    end
    if (cmd.capture) begin
      prev_rd <= prev_mem[note];
    end
  end

  // Event capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      note_r   <= note;
      mode_r   <= mode;
      held_hit <= held[note];
    end
  end

  // List control: held bits and count
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      held_count <= '0;
    end else if (unlink_go) begin
      held[note_r] <= 1'b0;
      held_count   <= held_count - lnps_pkg::COUNT_W'(1);
    end else if (cmd.drop) begin
      held[head] <= 1'b0;
      held_count <= held_count - lnps_pkg::COUNT_W'(1);
    end else if (cmd.append) begin
      held[note_r] <= 1'b1;
      held_count   <= held_count + lnps_pkg::COUNT_W'(1);
    end
  end

  // Head and tail pointers; meaningless while the list is empty
  always_ff @(posedge clk) begin
    if (unlink_go) begin
      if (note_r == head) begin
        head <= next_rd;
      end
      if (note_r == tail) begin
        tail <= prev_rd;
      end
    end else if (cmd.drop) begin
      head <= next_rd;
    end else if (cmd.append) begin
      if (held_count == '0) begin
        head <= note_r;
      end
      tail <= note_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (mode_r == lnps_pkg::MODE_ON) begin
        command   <= lnps_pkg::CMD_PLAY;
        play_note <= note_r;
        retrigger <= (held_count == lnps_pkg::COUNT_W'(1));
      end else if (held_count == '0) begin
        command   <= lnps_pkg::CMD_RELEASE;
        play_note <= '0;
        retrigger <= 1'b0;
      end else begin
        command   <= lnps_pkg::CMD_PLAY;
        play_note <= tail;
        retrigger <= 1'b0;
      end
    end
  end

  // Count stays within the list size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= lnps_pkg::COUNT_W'(lnps_pkg::DEPTH))
    else $error("held count above list size");

  // Count matches the held bits
  a_count_bits: assert property (@(posedge clk) disable iff (rst)
    int'(held_count) == $countones(held))
    else $error("held count disagrees with held bits");

  // After an append the new note is held and is the newest
  a_append_tail: assert property (@(posedge clk) disable iff (rst)
    cmd.append |=> (held[tail] && tail == $past(note_r)))
    else $error("appended note is not the held tail");

endmodule

[src/last_note_priority_stack.sv]
// Top level of the last-note priority stack for a monophonic voice.
// Instantiates lnps_ctrl and lnps_datapath; uses lnps_pkg.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------
//  event   | in_valid  | in_stall  | mode, note
//  result  | out_valid | out_stall | command, play_note, retrigger
//
// A note-on goes accept, unlink, append, result; a full list that lacks the
// note first reads and drops its oldest note; a note-off skips append.
// The steps are set by the one read and one write port on each link memory.
// Reset empties the list at once through the held bits; no clearing pass.
// The result register frees the event side: a new beat is taken while a
// result waits, and the sequencer only stalls in its last step if it is full.
module last_note_priority_stack (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [lnps_pkg::NOTE_W-1:0] note,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        command,
  output logic [lnps_pkg::NOTE_W-1:0] play_note,
  output logic                        retrigger
);

  lnps_pkg::lnps_cmd_t cmd;
  lnps_pkg::lnps_sts_t sts;

  lnps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lnps_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .note      (note),
    .cmd       (cmd),
    .sts       (sts),
    .command   (command),
    .play_note (play_note),
    .retrigger (retrigger)
  );

endmodule
